[design/bpcc_pkg.sv]
// ----------------------------------------------------------------------------
// Button chord classifier package
// Shared widths, register indexes, report and key codes, and the key lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package bpcc_pkg;

  // Width of the press and chord hold counters (8 to 32).
  localparam int unsigned COUNT_WIDTH = 16;
  // Width of every threshold register.
  localparam int unsigned TICK_W      = 16;
  // Width used when a counter is compared against a threshold.
  localparam int unsigned CMP_W       = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned KEY_W       = 4;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [TICK_W-1:0]      ticks_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [KEY_W-1:0]       key_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t CfgShortTicks     = 3'd0;
  localparam cfg_idx_t CfgLongTicks      = 3'd1;
  localparam cfg_idx_t CfgFuncStartTicks = 3'd2;
  localparam cfg_idx_t CfgFuncHomeTicks  = 3'd3;
  localparam cfg_idx_t CfgStartHomeTicks = 3'd4;

  // Key codes.
  localparam key_t KeyNone      = 4'd0;
  localparam key_t KeyFuncShort = 4'd1;
  localparam key_t KeyStrtShort = 4'd2;
  localparam key_t KeyHomeShort = 4'd3;
  localparam key_t KeyStrtLong  = 4'd4;
  localparam key_t KeyFuncLong  = 4'd5;
  localparam key_t KeyHomeLong  = 4'd6;
  localparam key_t KeyFuncStart = 4'd7;
  localparam key_t KeyFuncHome  = 4'd8;
  localparam key_t KeyStartHome = 4'd9;

  // Per-button report for one sample.
  typedef enum logic [1:0] {
    RepNone  = 2'd0,
    RepShort = 2'd1,
    RepLong  = 2'd2
  } rep_e;

  // What a button slice tells the chord logic about one sample.
  typedef struct packed {
    logic held_next;
    rep_e rep;
  } btn_status_t;

  function automatic count_t sat_inc(input count_t v);
    count_t r;
    r = (v == {COUNT_WIDTH{1'b1}}) ? v : v + count_t'(1);
    return r;
  endfunction

  // Pick the key code from the three reports; chord table in chord mode.
  function automatic key_t key_lookup(input logic chord, input rep_e rf,
                                      input rep_e rs, input rep_e rh);
    key_t k;
    k = KeyNone;
    if (!chord) begin
      if      (rf == RepShort && rs == RepNone  && rh == RepNone)  k = KeyFuncShort;
      else if (rf == RepNone  && rs == RepShort && rh == RepNone)  k = KeyStrtShort;
      else if (rf == RepNone  && rs == RepNone  && rh == RepShort) k = KeyHomeShort;
      else if (rf == RepNone  && rs == RepLong  && rh == RepNone)  k = KeyStrtLong;
      else if (rf == RepLong  && rs == RepNone  && rh == RepNone)  k = KeyFuncLong;
      else if (rf == RepNone  && rs == RepNone  && rh == RepLong)  k = KeyHomeLong;
    end else begin
      if      (rf == RepLong && rs == RepLong && rh == RepNone) k = KeyFuncStart;
      else if (rf == RepLong && rs == RepNone && rh == RepLong) k = KeyFuncHome;
      else if (rf == RepNone && rs == RepLong && rh == RepLong) k = KeyStartHome;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

[design/bpcc_button.sv]
// ----------------------------------------------------------------------------
// Button chord classifier: one button slice
// Held flag, hold counter and short/long/lock flags of a single button.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcc_button (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic                 pressed_i,
  input  wire logic                 clear_i,
  input  wire bpcc_pkg::ticks_t     short_ticks_i,
  input  wire bpcc_pkg::ticks_t     long_ticks_i,
  output bpcc_pkg::btn_status_t     status_o
);
  import bpcc_pkg::*;

  logic   held_q, held_d;
  count_t cnt_q, cnt_d;
  logic   short_q, short_d;
  logic   long_q, long_d;
  logic   lock_q, lock_d;
  rep_e   rep;

  always_comb begin
    held_d  = 1'b0;
    cnt_d   = '0;
    short_d = 1'b0;
    long_d  = 1'b0;
    lock_d  = 1'b0;
    rep     = RepNone;
    if (pressed_i) begin
      held_d  = 1'b1;
      cnt_d   = held_q ? sat_inc(cnt_q) : '0;
      short_d = short_q | (CMP_W'(cnt_d) > CMP_W'(short_ticks_i));
      long_d  = long_q;
      lock_d  = lock_q;
      if ((CMP_W'(cnt_d) > CMP_W'(long_ticks_i)) && !lock_q) begin
        long_d = 1'b1;
        lock_d = 1'b1;
        rep    = RepLong;
      end
    end else if (short_q && !long_q) begin
      rep = RepShort;
    end
  end

  assign status_o.held_next = held_d;
  assign status_o.rep       = rep;

  // Clear the whole slice when the chord logic drops back to single mode.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      cnt_q   <= '0;
      short_q <= 1'b0;
      long_q  <= 1'b0;
      lock_q  <= 1'b0;
    end else if (step_i) begin
      held_q  <= held_d  & ~clear_i;
      cnt_q   <= clear_i ? '0 : cnt_d;
      short_q <= short_d & ~clear_i;
      long_q  <= long_d  & ~clear_i;
      lock_q  <= lock_d  & ~clear_i;
    end
  end

endmodule

`default_nettype wire

[design/button_press_chord_classifier_top.sv]
// ----------------------------------------------------------------------------
// Button press and chord classifier, top level
// Short, long and two-button chord presses of func, start and home buttons.
// ----------------------------------------------------------------------------
// One sample of the three button levels is taken per accepted word, and every
// sample gives exactly one result word: a key code and the chord mode flag.
// The block takes a sample in every clock cycle unless a stalled result holds
// it off; the result appears in the cycle after the sample is accepted. All
// state updates are one pass of logic from the button state registers to the
// result register; its valid flag lets the next sample in as a waiting result is read,
// so a stalled output only blocks input once that register is full and not read.
// Thresholds are counted in samples and can be rewritten through the
// configuration port (always ready) while no sample is in flight; writes to
// an index beyond the five registers are dropped.
`default_nettype none

module button_press_chord_classifier_top (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // sample channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 func_button_i,
  input  wire logic                 start_button_i,
  input  wire logic                 home_button_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output bpcc_pkg::key_t            key_code_o,
  output logic                      multi_mode_o,
  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire bpcc_pkg::cfg_idx_t   cfg_index_i,
  input  wire bpcc_pkg::ticks_t     cfg_data_i
);
  import bpcc_pkg::*;

  // Threshold registers.
  ticks_t short_ticks_q, long_ticks_q;
  ticks_t fs_ticks_q, fh_ticks_q, sh_ticks_q;

  // Chord state.
  logic       chord_q, chord_d;
  logic [2:0] pattern_q, pattern_d;
  count_t     combo_cnt_q, combo_cnt_d;
  logic       combo_lock_q, combo_lock_d;

  // Result register.
  logic out_valid_q;
  key_t key_q, key_d;
  logic mode_q;

  logic accept;
  logic clear_all;

  btn_status_t st_func, st_start, st_home;

  // Accept a new sample whenever the result register is empty or drains now.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Button slices
  // --------------------------------------------------------------------------
  bpcc_button u_func (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .pressed_i     (func_button_i),
    .clear_i       (clear_all),
    .short_ticks_i (short_ticks_q),
    .long_ticks_i  (long_ticks_q),
    .status_o      (st_func)
  );

  bpcc_button u_start (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .pressed_i     (start_button_i),
    .clear_i       (clear_all),
    .short_ticks_i (short_ticks_q),
    .long_ticks_i  (long_ticks_q),
    .status_o      (st_start)
  );

  bpcc_button u_home (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .pressed_i     (home_button_i),
    .clear_i       (clear_all),
    .short_ticks_i (short_ticks_q),
    .long_ticks_i  (long_ticks_q),
    .status_o      (st_home)
  );

  // --------------------------------------------------------------------------
  // Chord mode and key selection
  // --------------------------------------------------------------------------
  logic       hf, hs, hh;
  logic [1:0] held_n;
  count_t     elapsed;
  logic       fire_fs, fire_fh, fire_sh;
  rep_e       rf, rs, rh;

  assign hf      = st_func.held_next;
  assign hs      = st_start.held_next;
  assign hh      = st_home.held_next;
  assign held_n  = 2'(hf) + 2'(hs) + 2'(hh);
  assign elapsed = sat_inc(combo_cnt_q);

  // Leaving chord mode: fewer than two buttons still down.
  assign clear_all = chord_q && (held_n <= 2'd1);

  // Only the first chord that reaches its threshold fires; it takes the lock.
  assign fire_fs = pattern_q[0] && !combo_lock_q &&
                   (CMP_W'(elapsed) >= CMP_W'(fs_ticks_q));
  assign fire_fh = pattern_q[1] && !combo_lock_q && !fire_fs &&
                   (CMP_W'(elapsed) >= CMP_W'(fh_ticks_q));
  assign fire_sh = pattern_q[2] && !combo_lock_q && !fire_fs && !fire_fh &&
                   (CMP_W'(elapsed) >= CMP_W'(sh_ticks_q));

  always_comb begin
    chord_d      = chord_q;
    pattern_d    = pattern_q;
    combo_cnt_d  = combo_cnt_q;
    combo_lock_d = combo_lock_q;
    rf           = st_func.rep;
    rs           = st_start.rep;
    rh           = st_home.rep;
    if (!chord_q) begin
      // Enter chord mode on exactly two held buttons; merge into old bits.
      if (held_n == 2'd2) begin
        pattern_d    = pattern_q | {hs & hh, hf & hh, hf & hs};
        combo_cnt_d  = '0;
        combo_lock_d = 1'b0;
        chord_d      = 1'b1;
      end
    end else if (clear_all) begin
      rf      = RepNone;
      rs      = RepNone;
      rh      = RepNone;
      chord_d = 1'b0;
    end else begin
      combo_cnt_d = elapsed;
      if (fire_fs || fire_fh || fire_sh) begin
        combo_cnt_d  = '0;
        combo_lock_d = 1'b1;
        rf           = fire_sh ? RepNone : RepLong;
        rs           = fire_fh ? RepNone : RepLong;
        rh           = fire_fs ? RepNone : RepLong;
      end
    end
    key_d = key_lookup(chord_d, rf, rs, rh);
    // A chord code consumes the pending chord bits and restarts the timer.
    if (chord_d && (key_d != KeyNone)) begin
      combo_cnt_d = '0;
      pattern_d   = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_ticks_q <= ticks_t'(30);
      long_ticks_q  <= ticks_t'(3000);
      fs_ticks_q    <= ticks_t'(3000);
      fh_ticks_q    <= ticks_t'(5000);
      sh_ticks_q    <= ticks_t'(3000);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgShortTicks:     short_ticks_q <= cfg_data_i;
        CfgLongTicks:      long_ticks_q  <= cfg_data_i;
        CfgFuncStartTicks: fs_ticks_q    <= cfg_data_i;
        CfgFuncHomeTicks:  fh_ticks_q    <= cfg_data_i;
        CfgStartHomeTicks: sh_ticks_q    <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chord_q      <= 1'b0;
      pattern_q    <= '0;
      combo_cnt_q  <= '0;
      combo_lock_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        chord_q      <= chord_d;
        pattern_q    <= pattern_d;
        combo_cnt_q  <= combo_cnt_d;
        combo_lock_q <= combo_lock_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  // Hold the result payload until a new sample replaces it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= key_d;
      mode_q <= chord_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_code_o   = key_q;
  assign multi_mode_o = mode_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Chord mode is only kept while at least two buttons are held.
  a_chord_needs_two : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chord_q |-> ($countones({u_func.held_q, u_start.held_q, u_home.held_q}) >= 2))
    else $error("chord mode with fewer than two held buttons");

  // Chord codes are only reported in chord mode.
  a_chord_code_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (key_q == KeyFuncStart || key_q == KeyFuncHome ||
                     key_q == KeyStartHome)) |-> mode_q)
    else $error("chord key code outside chord mode");

  // Single-button codes are only reported in single mode.
  a_single_code_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && key_q != KeyNone && key_q != KeyFuncStart &&
     key_q != KeyFuncHome && key_q != KeyStartHome) |-> !mode_q)
    else $error("single key code in chord mode");

  // An accepted sample always leaves a result in the output register.
  a_accept_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted sample produced no result");

endmodule

`default_nettype wire
